// ===== rtl/pwrr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwrr_pkg
// Shared constants, codes and controller/datapath interface types of the
// priority-weighted round-robin scheduler.
// ----------------------------------------------------------------------------
package pwrr_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ID_W       = 4;
   localparam int PRIO_W     = 4;
   localparam int QUANT_W    = 8;
   localparam int TICK_W     = 12;
   localparam int PRIO_LIMIT = 10;

   localparam logic [TICK_W-1:0]  TICK_MAX    = {TICK_W{1'b1}};
   localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(1);

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_ADD      = 3'd1,
      OP_EXIT     = 3'd2,
      OP_BLOCK    = 3'd3,
      OP_UNBLOCK  = 3'd4,
      OP_YIELD    = 3'd5,
      OP_SET_PRIO = 3'd6,
      OP_QUERY    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_READY   = 2'd1,
      ST_BLOCKED = 2'd2,
      ST_EXITED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WR_OP,
      S_RD_SLOT,
      S_SLOT_EVAL,
      S_RD_RUN,
      S_RUN_EVAL,
      S_SEARCH,
      S_RD_OUT,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      AS_SLOT,
      AS_RUN,
      AS_CAND
   } addr_sel_type;

   typedef enum logic [1:0] {
      TS_ZERO,
      TS_QUANT,
      TS_INC
   } tick_sel_type;

   typedef struct packed {
      logic         load_req;
      addr_sel_type addr_sel;
      logic         wr_status;
      status_type   status_val;
      logic         wr_prio;
      logic         wr_tick;
      tick_sel_type tick_sel;
      logic         search_init;
      logic         search_step;
      logic         take_cand;
      logic         set_none;
      logic         set_rej;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   slot_ok;
      logic   prio_ok;
      logic   need_search;
      logic   cand_ready;
      logic   search_last;
      logic   rsp_free;
   } stat_type;

endpackage

// ===== rtl/pwrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwrr_ctrl
// Sequencer of the scheduler: decodes each event and steps the datapath
// through table reads, writes and the round-robin search.
// ----------------------------------------------------------------------------
module pwrr_ctrl
   import pwrr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      cmd             = '0;
      cmd.addr_sel    = AS_SLOT;
      cmd.status_val  = ST_UNUSED;
      cmd.tick_sel    = TS_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_TICK: begin
                  state_in = S_RD_RUN;
               end
               OP_ADD, OP_EXIT, OP_BLOCK, OP_UNBLOCK: begin
                  state_in = stat.slot_ok ? S_WR_OP : S_RD_OUT;
               end
               OP_YIELD: begin
                  state_in = stat.slot_ok ? S_RD_SLOT : S_RD_RUN;
               end
               OP_SET_PRIO: begin
                  if (stat.slot_ok) begin
                     state_in = S_RD_SLOT;
                  end else begin
                     cmd.set_rej = 1'b1;
                     state_in    = S_RD_OUT;
                  end
               end
               OP_QUERY: begin
                  state_in = S_RD_OUT;
               end
               default: begin
                  state_in = S_RD_OUT;
               end
            endcase
         end
         S_WR_OP: begin
            cmd.wr_status = 1'b1;
            unique case (stat.op)
               OP_ADD: begin
                  cmd.status_val = ST_READY;
                  cmd.wr_prio    = 1'b1;
                  cmd.wr_tick    = 1'b1;
                  cmd.tick_sel   = TS_ZERO;
               end
               OP_EXIT:    cmd.status_val = ST_EXITED;
               OP_BLOCK:   cmd.status_val = ST_BLOCKED;
               OP_UNBLOCK: cmd.status_val = ST_READY;
               default: begin
                  cmd.wr_status = 1'b0;
               end
            endcase
            state_in = S_RD_OUT;
         end
         S_RD_SLOT: begin
            state_in = S_SLOT_EVAL;
         end
         S_SLOT_EVAL: begin
            if (stat.op == OP_YIELD) begin
               cmd.wr_tick  = 1'b1;
               cmd.tick_sel = TS_QUANT;
               state_in     = S_RD_RUN;
            end else begin
               if (stat.prio_ok) begin
                  cmd.wr_prio = 1'b1;
               end else begin
                  cmd.set_rej = 1'b1;
               end
               state_in = S_RD_OUT;
            end
         end
         S_RD_RUN: begin
            cmd.addr_sel = AS_RUN;
            state_in     = S_RUN_EVAL;
         end
         S_RUN_EVAL: begin
            cmd.addr_sel = AS_RUN;
            if (stat.need_search) begin
               cmd.search_init = 1'b1;
               state_in        = S_SEARCH;
            end else begin
               cmd.wr_tick  = 1'b1;
               cmd.tick_sel = TS_INC;
               state_in     = S_RD_OUT;
            end
         end
         S_SEARCH: begin
            cmd.addr_sel = AS_CAND;
            priority if (stat.cand_ready) begin
               cmd.wr_tick   = 1'b1;
               cmd.tick_sel  = TS_ZERO;
               cmd.take_cand = 1'b1;
               state_in      = S_RD_OUT;
            end else if (stat.search_last) begin
               cmd.set_none = 1'b1;
               state_in     = S_RD_OUT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_RD_OUT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
      else $error("accepted transaction did not start decoding");

   a_rsp_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (stat.rsp_free && state_ff == S_OUT))
      else $error("result loaded while output register busy");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && stat.search_last) |=> (state_ff == S_RD_OUT))
      else $error("search ran past the last candidate");

   a_single_tick_write: assert property (@(posedge clock) disable iff (reset)
      cmd.take_cand |-> (cmd.wr_tick && cmd.tick_sel == TS_ZERO && !cmd.set_none))
      else $error("switch without clearing the new slot count");

endmodule

// ===== rtl/pwrr_datapath.sv =====
// ----------------------------------------------------------------------------
// pwrr_datapath
// Slot tables, ready vector, running slot, search candidate, quantum
// register and the result register of the scheduler.
// ----------------------------------------------------------------------------
module pwrr_datapath
   import pwrr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [QUANT_W-1:0] csr_write_data,
   input  logic [2:0]         req_type,
   input  logic [3:0]         req_slot_id,
   input  logic [PRIO_W-1:0]  req_new_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_running_id,
   output logic               rsp_switched,
   output logic               rsp_none_ready,
   output logic               rsp_rejected,
   output logic [1:0]         rsp_slot_state,
   output logic [PRIO_W-1:0]  rsp_slot_priority,
   input  cmd_type            cmd,
   output stat_type           stat
);

   op_type              op_ff;
   logic [3:0]          slot_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [QUANT_W-1:0]  quantum_ff;
   logic [SLOT_W-1:0]   run_ff;
   logic [SLOT_W-1:0]   cand_ff;
   logic [SLOT_W-1:0]   cnt_ff;
   logic                sw_ff;
   logic                none_ff;
   logic                rej_ff;
   logic [NUM_SLOTS-1:0] ready_ff;
   logic [NUM_SLOTS-1:0] st_wr_ff;
   logic [NUM_SLOTS-1:0] pr_wr_ff;
   logic [NUM_SLOTS-1:0] tk_wr_ff;

   status_type          status_mem [NUM_SLOTS];
   logic [PRIO_W-1:0]   prio_mem   [NUM_SLOTS];
   logic [TICK_W-1:0]   tick_mem   [NUM_SLOTS];

   status_type          st_rd_ff;
   logic [PRIO_W-1:0]   pr_rd_ff;
   logic [TICK_W-1:0]   tk_rd_ff;
   logic                st_vld_ff;
   logic                pr_vld_ff;
   logic                tk_vld_ff;
   logic [SLOT_W-1:0]   rd_addr_ff;

   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_running_ff;
   logic                rsp_sw_ff;
   logic                rsp_none_ff;
   logic                rsp_rej_ff;
   logic [1:0]          rsp_state_ff;
   logic [PRIO_W-1:0]   rsp_prio_ff;

   logic [SLOT_W-1:0]   slot_addr;
   logic [SLOT_W-1:0]   addr;
   logic                slot_ok;
   status_type          rd_status;
   logic [PRIO_W-1:0]   rd_prio;
   logic [TICK_W-1:0]   rd_tick;
   logic [TICK_W-1:0]   quantum;
   logic [TICK_W-1:0]   tick_inc;
   logic [TICK_W-1:0]   tick_wr;
   logic [SLOT_W-1:0]   run_next;
   logic [SLOT_W-1:0]   cand_next;
   logic                rsp_free;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(NUM_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

   assign slot_addr = SLOT_W'(slot_ff);
   assign slot_ok   = (32'(slot_ff) < 32'(NUM_SLOTS));
   assign run_next  = next_slot(run_ff);
   assign cand_next = next_slot(cand_ff);

   always_comb begin
      unique case (cmd.addr_sel)
         AS_SLOT: addr = slot_addr;
         AS_RUN:  addr = run_ff;
         AS_CAND: addr = cand_ff;
         default: addr = slot_addr;
      endcase
   end

   assign rd_status = st_vld_ff ? st_rd_ff :
                      ((rd_addr_ff == '0) ? ST_READY : ST_UNUSED);
   assign rd_prio   = pr_vld_ff ? pr_rd_ff :
                      ((rd_addr_ff == '0) ? PRIO_W'(1) : '0);
   assign rd_tick   = tk_vld_ff ? tk_rd_ff : '0;

   assign quantum  = TICK_W'(TICK_W'(quantum_ff) * TICK_W'(rd_prio));
   assign tick_inc = (rd_tick == TICK_MAX) ? rd_tick : rd_tick + TICK_W'(1);

   always_comb begin
      unique case (cmd.tick_sel)
         TS_ZERO:  tick_wr = '0;
         TS_QUANT: tick_wr = quantum;
         TS_INC:   tick_wr = tick_inc;
         default:  tick_wr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_status) begin
         status_mem[addr] <= cmd.status_val;
      end
      if (cmd.wr_prio) begin
         prio_mem[addr] <= prio_ff;
      end
      if (cmd.wr_tick) begin
         tick_mem[addr] <= tick_wr;
      end
      st_rd_ff   <= status_mem[addr];
      pr_rd_ff   <= prio_mem[addr];
      tk_rd_ff   <= tick_mem[addr];
      st_vld_ff  <= st_wr_ff[addr];
      pr_vld_ff  <= pr_wr_ff[addr];
      tk_vld_ff  <= tk_wr_ff[addr];
      rd_addr_ff <= addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= op_type'(req_type);
         slot_ff <= req_slot_id;
         prio_ff <= req_new_priority;
      end
      if (cmd.search_init) begin
         cand_ff <= run_next;
      end else if (cmd.search_step) begin
         cand_ff <= cand_next;
      end
      if (cmd.search_init) begin
         cnt_ff <= '0;
      end else if (cmd.search_step) begin
         cnt_ff <= cnt_ff + SLOT_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_running_ff <= ID_W'(run_ff);
         rsp_sw_ff      <= sw_ff;
         rsp_none_ff    <= none_ff;
         rsp_rej_ff     <= rej_ff;
         rsp_state_ff   <= slot_ok ? rd_status : ST_UNUSED;
         rsp_prio_ff    <= slot_ok ? rd_prio : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANT_RESET;
         run_ff       <= '0;
         sw_ff        <= 1'b0;
         none_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         ready_ff     <= NUM_SLOTS'(1);
         st_wr_ff     <= '0;
         pr_wr_ff     <= '0;
         tk_wr_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            quantum_ff <= csr_write_data;
         end
         if (cmd.take_cand) begin
            run_ff <= cand_ff;
         end
         if (cmd.load_req) begin
            sw_ff   <= 1'b0;
            none_ff <= 1'b0;
            rej_ff  <= 1'b0;
         end else begin
            if (cmd.take_cand) begin
               sw_ff <= 1'b1;
            end
            if (cmd.set_none) begin
               none_ff <= 1'b1;
            end
            if (cmd.set_rej) begin
               rej_ff <= 1'b1;
            end
         end
         if (cmd.wr_status) begin
            ready_ff[addr] <= (cmd.status_val == ST_READY);
            st_wr_ff[addr] <= 1'b1;
         end
         if (cmd.wr_prio) begin
            pr_wr_ff[addr] <= 1'b1;
         end
         if (cmd.wr_tick) begin
            tk_wr_ff[addr] <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.op          = op_ff;
      stat.slot_ok     = slot_ok;
      stat.prio_ok     = (rd_status == ST_READY || rd_status == ST_BLOCKED) &&
                         (prio_ff != '0) && (prio_ff < PRIO_W'(PRIO_LIMIT));
      stat.need_search = !ready_ff[run_ff] || (rd_tick >= quantum);
      stat.cand_ready  = ready_ff[cand_ff];
      stat.search_last = (cnt_ff == SLOT_W'(NUM_SLOTS - 1));
      stat.rsp_free    = rsp_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_id    = rsp_running_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_none_ready    = rsp_none_ff;
   assign rsp_rejected      = rsp_rej_ff;
   assign rsp_slot_state    = rsp_state_ff;
   assign rsp_slot_priority = rsp_prio_ff;

endmodule

// ===== rtl/priority_weighted_round_robin_sched_top.sv =====
// Per event: add/exit/block/unblock write the slot table; set priority reads the slot,
// then writes or rejects the priority; tick reads the running slot and, if needed,
// searches up to NUM_SLOTS slots, one slot a cycle in the search state; yield first
// sets its slot's tick count to the quantum. The sequencer takes one event at a time;
// the next is accepted in the cycle after the result is loaded, even under rsp_stall.
// Reset is synchronous: slot 0 ready with priority 1, quantum_ticks 1, no clearing pass.
// ----------------------------------------------------------------------------
// priority_weighted_round_robin_sched_top
// Priority-weighted round-robin task scheduler: sequencer plus slot-table
// datapath, one result transaction per event transaction.
// ----------------------------------------------------------------------------
module priority_weighted_round_robin_sched_top
   import pwrr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [QUANT_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [3:0]         req_slot_id,
   input  logic [PRIO_W-1:0]  req_new_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_running_id,
   output logic               rsp_switched,
   output logic               rsp_none_ready,
   output logic               rsp_rejected,
   output logic [1:0]         rsp_slot_state,
   output logic [PRIO_W-1:0]  rsp_slot_priority
);

   cmd_type  cmd;
   stat_type stat;

   pwrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwrr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_type          (req_type),
      .req_slot_id       (req_slot_id),
      .req_new_priority  (req_new_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_running_id    (rsp_running_id),
      .rsp_switched      (rsp_switched),
      .rsp_none_ready    (rsp_none_ready),
      .rsp_rejected      (rsp_rejected),
      .rsp_slot_state    (rsp_slot_state),
      .rsp_slot_priority (rsp_slot_priority),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
